// ===== sv/pdc_pkg.sv =====
`timescale 1ns / 1ps

package pdc_pkg;

    // Field and register widths
    localparam int DATA_W      = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int BURST_W     = 17;
    localparam int PROD_W      = 32;   // unsigned gain times unsigned delay
    localparam int ERR_PROD_W  = 34;   // unsigned gain times signed delay error
    localparam int TERM_W      = 36;   // sum of the two gain terms
    localparam int SUM_W       = 41;   // probability plus sixteen times the terms

    // Reset values of the configuration registers
    localparam logic [DATA_W-1:0] TARGET_DELAY_RST    = 16'd15;
    localparam logic [DATA_W-1:0] UPDATE_PERIOD_RST   = 16'd30;
    localparam logic [DATA_W-1:0] ALPHA_GAIN_RST      = 16'd512;
    localparam logic [DATA_W-1:0] BETA_GAIN_RST       = 16'd5120;
    localparam logic [DATA_W-1:0] PROB_CEILING_RST    = 16'd6554;
    localparam logic [DATA_W-1:0] BURST_ALLOWANCE_RST = 16'd150;
    localparam logic [BURST_W-1:0] BURST_TIMER_RST    = 17'd150;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_DELAY    = 3'd0,
        REG_UPDATE_PERIOD   = 3'd1,
        REG_ALPHA_GAIN      = 3'd2,
        REG_BETA_GAIN       = 3'd3,
        REG_PROB_CEILING    = 3'd4,
        REG_BURST_ALLOWANCE = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        VERDICT_ACCEPT = 2'd0,
        VERDICT_EARLY  = 2'd1,
        VERDICT_TAIL   = 2'd2,
        VERDICT_NONE   = 2'd3
    } verdict_t;

    typedef enum logic {
        OP_ARRIVAL   = 1'b0,
        OP_DEPARTURE = 1'b1
    } op_t;

    typedef struct packed {
        logic [DATA_W-1:0] target_delay;
        logic [DATA_W-1:0] update_period;
        logic [DATA_W-1:0] alpha_gain;
        logic [DATA_W-1:0] beta_gain;
        logic [DATA_W-1:0] prob_ceiling;
        logic [DATA_W-1:0] burst_allowance;
    } cfg_regs_t;

    typedef struct packed {
        logic              op;
        logic [DATA_W-1:0] queue_delay;
        logic [DATA_W-1:0] random_value;
        logic              queue_full;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        verdict;
        logic [DATA_W-1:0] drop_probability;
    } out_item_t;

    // Classified item handed from the front end to the back end
    typedef struct packed {
        logic                         op;
        logic                         over_target;
        logic                         queue_full;
        logic [DATA_W-1:0]            queue_delay;
        logic [DATA_W-1:0]            random_value;
        logic signed [ERR_PROD_W-1:0] err_prod;
        logic [PROD_W-1:0]            beta_delay;
    } cls_item_t;

    // Head of a queue toward its consumer
    typedef struct packed {
        logic      valid;
        cls_item_t item;
    } cls_head_t;

endpackage

// ===== sv/pdc_config.sv =====
`timescale 1ns / 1ps

module pdc_config (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [pdc_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [pdc_pkg::DATA_W-1:0]  cfg_wdata,
    output pdc_pkg::cfg_regs_t          cfg
);
    import pdc_pkg::*;

    cfg_regs_t cfg_reg;
    cfg_regs_t cfg_next;

    // Decode the register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_addr))
                REG_TARGET_DELAY:    cfg_next.target_delay    = cfg_wdata;
                REG_UPDATE_PERIOD:   cfg_next.update_period   = cfg_wdata;
                REG_ALPHA_GAIN:      cfg_next.alpha_gain      = cfg_wdata;
                REG_BETA_GAIN:       cfg_next.beta_gain       = cfg_wdata;
                REG_PROB_CEILING:    cfg_next.prob_ceiling    = cfg_wdata;
                REG_BURST_ALLOWANCE: cfg_next.burst_allowance = cfg_wdata;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_delay    <= TARGET_DELAY_RST;
            cfg_reg.update_period   <= UPDATE_PERIOD_RST;
            cfg_reg.alpha_gain      <= ALPHA_GAIN_RST;
            cfg_reg.beta_gain       <= BETA_GAIN_RST;
            cfg_reg.prob_ceiling    <= PROB_CEILING_RST;
            cfg_reg.burst_allowance <= BURST_ALLOWANCE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/pdc_front.sv =====
`timescale 1ns / 1ps

module pdc_front (
    input  pdc_pkg::in_item_t  item,
    input  pdc_pkg::cfg_regs_t cfg,
    output pdc_pkg::cls_item_t cls
);
    import pdc_pkg::*;

    logic signed [DATA_W:0]       delay_err;
    logic signed [ERR_PROD_W-1:0] err_prod;
    logic [PROD_W-1:0]            beta_delay;

    // Form the state-free gain products of the update
    always_comb
    begin
        delay_err  = $signed({1'b0, item.queue_delay}) - $signed({1'b0, cfg.target_delay});
        err_prod   = ERR_PROD_W'($signed({1'b0, cfg.alpha_gain})) * ERR_PROD_W'(delay_err);
        beta_delay = PROD_W'(cfg.beta_gain) * PROD_W'(item.queue_delay);
    end

    // Classify the transaction
    always_comb
    begin
        cls.op           = item.op;
        cls.over_target  = item.queue_delay > cfg.target_delay;
        cls.queue_full   = item.queue_full;
        cls.queue_delay  = item.queue_delay;
        cls.random_value = item.random_value;
        cls.err_prod     = err_prod;
        cls.beta_delay   = beta_delay;
    end

endmodule

// ===== sv/pdc_queue.sv =====
`timescale 1ns / 1ps

module pdc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  pdc_pkg::cls_item_t push_item,
    output logic               full,
    input  logic               pop,
    output pdc_pkg::cls_head_t head
);
    import pdc_pkg::*;

    cls_item_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full     = count_reg == 2'd2;
    assign do_push  = push && !full;
    assign do_pop   = pop && (count_reg != 2'd0);

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head.valid = count_reg != 2'd0;
    assign head.item  = entry_reg[rd_ptr_reg];

endmodule

// ===== sv/pdc_back.sv =====
`timescale 1ns / 1ps

module pdc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  pdc_pkg::cfg_regs_t cfg,
    input  pdc_pkg::cls_head_t head,
    output logic               take,
    output logic               empty,
    input  logic               pop,
    output pdc_pkg::out_item_t result
);
    import pdc_pkg::*;

    // Controller state
    logic [DATA_W-1:0]  ticks_reg;
    logic [DATA_W-1:0]  ticks_next;
    logic [DATA_W-1:0]  prob_reg;
    logic [DATA_W-1:0]  prob_next;
    logic [DATA_W-1:0]  prev_delay_reg;
    logic [DATA_W-1:0]  prev_delay_next;
    logic [BURST_W-1:0] burst_reg;
    logic [BURST_W-1:0] burst_next;
    logic [PROD_W-1:0]  beta_prev_reg;
    logic [PROD_W-1:0]  beta_prev_next;

    // Result queue
    out_item_t  res_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_pop;

    logic                     do_update;
    logic signed [TERM_W-1:0] term;
    logic signed [SUM_W-1:0]  sum;
    logic [DATA_W-1:0]        clamped;
    logic [DATA_W-1:0]        prob_new;
    logic [BURST_W-1:0]       burst_new;
    logic [1:0]               verdict;

    assign take   = head.valid && (count_reg != 2'd2);
    assign do_pop = pop && (count_reg != 2'd0);

    // Run the probability update and clamp
    always_comb
    begin
        do_update = ticks_reg >= cfg.update_period;
        term = TERM_W'(head.item.err_prod)
             + $signed({{(TERM_W-PROD_W){1'b0}}, head.item.beta_delay})
             - $signed({{(TERM_W-PROD_W){1'b0}}, beta_prev_reg});
        sum  = $signed({{(SUM_W-DATA_W){1'b0}}, prob_reg})
             + ($signed(SUM_W'(term)) <<< 4);
        if (sum < 0)
        begin
            clamped = '0;
        end
        else if (sum > $signed({{(SUM_W-DATA_W){1'b0}}, cfg.prob_ceiling}))
        begin
            clamped = cfg.prob_ceiling;
        end
        else
        begin
            clamped = sum[DATA_W-1:0];
        end
        prob_new = do_update ? clamped : prob_reg;
    end

    // Update the burst timer
    always_comb
    begin
        burst_new = burst_reg;
        if (do_update)
        begin
            if (head.item.over_target)
            begin
                burst_new = '0;
            end
            else if (burst_reg < {1'b0, cfg.burst_allowance})
            begin
                burst_new = burst_reg + {1'b0, cfg.update_period};
            end
        end
    end

    // Decide the verdict
    always_comb
    begin
        if (op_t'(head.item.op) == OP_DEPARTURE)
        begin
            verdict = VERDICT_NONE;
        end
        else if (burst_new < {1'b0, cfg.burst_allowance} && head.item.over_target
                 && head.item.random_value < prob_new)
        begin
            verdict = VERDICT_EARLY;
        end
        else if (head.item.queue_full)
        begin
            verdict = VERDICT_TAIL;
        end
        else
        begin
            verdict = VERDICT_ACCEPT;
        end
    end

    // Next controller state
    always_comb
    begin
        ticks_next      = ticks_reg;
        prob_next       = prob_reg;
        prev_delay_next = prev_delay_reg;
        burst_next      = burst_reg;
        beta_prev_next  = PROD_W'(cfg.beta_gain) * PROD_W'(prev_delay_reg);
        if (take)
        begin
            prob_next  = prob_new;
            burst_next = burst_new;
            if (do_update)
            begin
                ticks_next      = DATA_W'(1);
                prev_delay_next = head.item.queue_delay;
                beta_prev_next  = head.item.beta_delay;
            end
            else if (ticks_reg != '1)
            begin
                ticks_next = ticks_reg + DATA_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg      <= '0;
            prob_reg       <= '0;
            prev_delay_reg <= '0;
            burst_reg      <= BURST_TIMER_RST;
            beta_prev_reg  <= '0;
        end
        else
        begin
            ticks_reg      <= ticks_next;
            prob_reg       <= prob_next;
            prev_delay_reg <= prev_delay_next;
            burst_reg      <= burst_next;
            beta_prev_reg  <= beta_prev_next;
        end
    end

    // Hold results until popped
    always_comb
    begin
        count_next = count_reg;
        if (take && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !take)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (take)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg[wr_ptr_reg].verdict          <= verdict;
            res_reg[wr_ptr_reg].drop_probability <= prob_new;
        end
    end

    assign empty  = count_reg == 2'd0;
    assign result = res_reg[rd_ptr_reg];

endmodule

// ===== sv/pie_drop_controller.sv =====
`timescale 1ns / 1ps
// Path: an accepted transaction waits in the input queue; the back end takes it and stores
// its result (empty low). Gain products are formed before that queue, the update after it.
// Throughput: one transaction per cycle while neither queue is full.
// Reset: asynchronous, active low; registers return to their defaults, probability and
// delay history clear, the burst timer loads 150 and both queues empty.
module pie_drop_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  pdc_pkg::in_item_t             item,
    output logic                          empty,
    input  logic                          pop,
    output pdc_pkg::out_item_t            result,
    input  logic                          cfg_wr_en,
    input  logic [pdc_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [pdc_pkg::DATA_W-1:0]    cfg_wdata
);
    import pdc_pkg::*;

    cfg_regs_t cfg;
    cls_item_t cls;
    cls_head_t head;
    logic      take;

    pdc_config u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pdc_front u_front (
        .item (item),
        .cfg  (cfg),
        .cls  (cls)
    );

    pdc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (cls),
        .full      (full),
        .pop       (take),
        .head      (head)
    );

    pdc_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .head   (head),
        .take   (take),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

endmodule

// ===== dv/pie_drop_checker.sv =====
`timescale 1ns / 1ps

module pie_drop_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic                          full,
    input  pdc_pkg::in_item_t             item,
    input  logic                          empty,
    input  logic                          pop,
    input  pdc_pkg::out_item_t            result,
    input  logic                          cfg_wr_en,
    input  logic [pdc_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [pdc_pkg::DATA_W-1:0]    cfg_wdata,
    output int                            outstanding,
    output int                            mismatch_count
);

    import pdc_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Shadow copy of the configuration registers
    logic [DATA_W-1:0]  target_delay;
    logic [DATA_W-1:0]  update_period;
    logic [DATA_W-1:0]  alpha_gain;
    logic [DATA_W-1:0]  beta_gain;
    logic [DATA_W-1:0]  prob_ceiling;
    logic [DATA_W-1:0]  burst_allowance;

    // Controller state as the block should hold it
    logic [DATA_W-1:0]  ticks_since_update;
    logic [DATA_W-1:0]  prob_state;
    logic [DATA_W-1:0]  last_delay;
    logic [BURST_W-1:0] burst_timer;

    out_item_t          pending_verdicts[$];
    int                 error_total;

    // Count a failure and print the first few
    task automatic note_failure(input string msg);
        error_total++;
        if (error_total <= REPORT_LIMIT)
            $display("%s", msg);
    endtask

    // Mirror one register write
    task automatic shadow_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] v);
        case (cfg_idx_t'(idx))
            REG_TARGET_DELAY:    target_delay = v;
            REG_UPDATE_PERIOD:   update_period = v;
            REG_ALPHA_GAIN:      alpha_gain = v;
            REG_BETA_GAIN:       beta_gain = v;
            REG_PROB_CEILING:    prob_ceiling = v;
            REG_BURST_ALLOWANCE: burst_allowance = v;
            default: ;
        endcase
    endtask

    // Advance the controller by one tick and work out the verdict it gives
    task automatic run_controller_step(input in_item_t it, output out_item_t res);
        longint   d;
        longint   t;
        longint   prev;
        longint   a;
        longint   b;
        longint   next_prob;
        verdict_t v;
        if (ticks_since_update >= update_period)
        begin
            d = longint'(it.queue_delay);
            t = longint'(target_delay);
            prev = longint'(last_delay);
            a = longint'(alpha_gain);
            b = longint'(beta_gain);
            next_prob = longint'(prob_state) + 16 * (a * (d - t) + b * (d - prev));
            if (next_prob < 0)
                next_prob = 0;
            if (next_prob > longint'(prob_ceiling))
                next_prob = longint'(prob_ceiling);
            prob_state = next_prob[DATA_W-1:0];
            last_delay = it.queue_delay;
            ticks_since_update = '0;
            // Clear the burst timer on congestion, else let it run up
            if (it.queue_delay > target_delay)
                burst_timer = '0;
            else if (burst_timer < {1'b0, burst_allowance})
                burst_timer = burst_timer + {1'b0, update_period};
        end

        if (it.op == OP_DEPARTURE)
            v = VERDICT_NONE;
        else if (burst_timer < {1'b0, burst_allowance} && it.queue_delay > target_delay
                 && it.random_value < prob_state)
            v = VERDICT_EARLY;
        else if (it.queue_full)
            v = VERDICT_TAIL;
        else
            v = VERDICT_ACCEPT;

        if (ticks_since_update != 16'hFFFF)
            ticks_since_update = ticks_since_update + DATA_W'(1);

        res.verdict = v;
        res.drop_probability = prob_state;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        out_item_t predicted;
        out_item_t oldest;
        if (!rst_n)
        begin
            target_delay = TARGET_DELAY_RST;
            update_period = UPDATE_PERIOD_RST;
            alpha_gain = ALPHA_GAIN_RST;
            beta_gain = BETA_GAIN_RST;
            prob_ceiling = PROB_CEILING_RST;
            burst_allowance = BURST_ALLOWANCE_RST;
            ticks_since_update = '0;
            prob_state = '0;
            last_delay = '0;
            burst_timer = BURST_TIMER_RST;
            pending_verdicts.delete();
            error_total = 0;
            outstanding <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                shadow_write(cfg_addr, cfg_wdata);

            // Predict every accepted transaction
            if (push && !full)
            begin
                run_controller_step(item, predicted);
                pending_verdicts.push_back(predicted);
            end

            // Compare every delivered result with the oldest prediction
            if (pop && !empty)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    note_failure($sformatf("[checker] unexpected result: verdict %0d prob %0d",
                                           result.verdict, result.drop_probability));
                end
                else
                begin
                    oldest = pending_verdicts.pop_front();
                    if (result.verdict !== oldest.verdict)
                        note_failure($sformatf("[checker] verdict: expected %0d, got %0d",
                                               oldest.verdict, result.verdict));
                    if (result.drop_probability !== oldest.drop_probability)
                        note_failure($sformatf("[checker] probability: expected %0d, got %0d",
                                               oldest.drop_probability,
                                               result.drop_probability));
                end
            end

            outstanding <= pending_verdicts.size();
            mismatch_count <= error_total;
        end
    end

endmodule

// ===== dv/tb_pie_drop_controller.sv =====
`timescale 1ns / 1ps

module tb_pie_drop_controller;

    import pdc_pkg::*;

    localparam int IDLE_LIMIT     = 2000;
    localparam int PHASE_ITEMS    = 150;
    localparam int RANDOM_PHASES  = 9;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    in_item_t             item = '0;
    logic                 full;
    logic                 empty;
    logic                 pop = 1'b0;
    out_item_t            result;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [DATA_W-1:0]    cfg_wdata = '0;

    int                   outstanding;
    int                   mismatch_count;
    int                   idle_cycles = 0;
    int                   burst_left = 0;
    int                   stall_mode = 0;
    int                   stall_left = 0;
    logic [DATA_W-1:0]    cur_target = TARGET_DELAY_RST;

    always #6 clk = ~clk;

    pie_drop_controller DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    pie_drop_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .item           (item),
        .empty          (empty),
        .pop            (pop),
        .result         (result),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .outstanding    (outstanding),
        .mismatch_count (mismatch_count)
    );

    // Stall the result side in changing patterns
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 96);
        end
        stall_left--;
        case (stall_mode)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 3) != 0);
            2: pop <= ($urandom_range(0, 3) == 0);
            default: pop <= (stall_left % 8 == 0);
        endcase
    end

    // End the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[pie_drop_controller] ERROR");
                $finish;
            end
        end
    end

    function automatic in_item_t make_item(input op_t op, input int delay, input int rnd,
                                           input logic q_full);
        in_item_t it;
        it.op = op;
        it.queue_delay = delay[DATA_W-1:0];
        it.random_value = rnd[DATA_W-1:0];
        it.queue_full = q_full;
        return it;
    endfunction

    // Mostly delays around the target, so that the controller moves both ways
    function automatic in_item_t random_item();
        int   d;
        int   rnd;
        op_t  op;
        op = ($urandom_range(0, 4) == 0) ? OP_DEPARTURE : OP_ARRIVAL;
        if ($urandom_range(0, 9) < 7)
            d = int'(cur_target) + int'($urandom_range(0, 96)) - 48;
        else
            d = $urandom_range(0, 65535);
        if (d < 0)
            d = 0;
        if (d > 65535)
            d = 65535;
        rnd = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 8191);
        return make_item(op, d, rnd, $urandom_range(0, 3) == 0);
    endfunction

    function automatic cfg_regs_t random_settings();
        cfg_regs_t s;
        s.target_delay = DATA_W'($urandom_range(0, 400));
        s.update_period = ($urandom_range(0, 3) == 0) ? DATA_W'($urandom_range(0, 2))
                                                      : DATA_W'($urandom_range(3, 60));
        s.alpha_gain = DATA_W'($urandom_range(0, 65535));
        s.beta_gain = DATA_W'($urandom_range(0, 65535));
        s.prob_ceiling = DATA_W'($urandom_range(0, 65535));
        s.burst_allowance = DATA_W'($urandom_range(0, 800));
        return s;
    endfunction

    // Offer one item, in bursts separated by random gaps
    task automatic send_item(input in_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        burst_left--;
    endtask

    // Hold off until every result has come back
    task automatic drain();
        push <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [DATA_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= v;
        @(posedge clk);
    endtask

    task automatic load_settings(input cfg_regs_t s);
        write_reg(REG_TARGET_DELAY, s.target_delay);
        write_reg(REG_UPDATE_PERIOD, s.update_period);
        write_reg(REG_ALPHA_GAIN, s.alpha_gain);
        write_reg(REG_BETA_GAIN, s.beta_gain);
        write_reg(REG_PROB_CEILING, s.prob_ceiling);
        write_reg(REG_BURST_ALLOWANCE, s.burst_allowance);
        cfg_wr_en <= 1'b0;
        cur_target = s.target_delay;
    endtask

    initial
    begin
        cfg_regs_t plan[RANDOM_PHASES];

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes under reset settings
        send_item(make_item(OP_ARRIVAL, 0, 0, 1'b0));
        send_item(make_item(OP_ARRIVAL, 65535, 65535, 1'b1));
        send_item(make_item(OP_DEPARTURE, 65535, 0, 1'b0));
        send_item(make_item(OP_DEPARTURE, 0, 65535, 1'b1));
        send_item(make_item(OP_ARRIVAL, 16, 0, 1'b1));
        send_item(make_item(OP_ARRIVAL, 15, 65535, 1'b0));
        send_item(make_item(OP_ARRIVAL, 65535, 0, 1'b0));
        send_item(make_item(OP_DEPARTURE, 0, 0, 1'b0));
        drain();

        // Update on every tick with maximum gains: early drop, tail drop, fall back
        load_settings('{16'd100, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_item(make_item(OP_ARRIVAL, 200, 0, 1'b0));
        send_item(make_item(OP_ARRIVAL, 200, 65534, 1'b0));
        send_item(make_item(OP_ARRIVAL, 200, 65535, 1'b1));
        send_item(make_item(OP_ARRIVAL, 200, 65535, 1'b0));
        send_item(make_item(OP_DEPARTURE, 200, 0, 1'b1));
        send_item(make_item(OP_ARRIVAL, 100, 0, 1'b0));
        send_item(make_item(OP_ARRIVAL, 101, 0, 1'b1));
        send_item(make_item(OP_ARRIVAL, 0, 0, 1'b1));
        send_item(make_item(OP_DEPARTURE, 65535, 65535, 1'b1));
        send_item(make_item(OP_ARRIVAL, 65535, 0, 1'b0));
        drain();

        // Settings for the random part: extremes, reset values, random, top and low ceiling, unit period
        plan[0] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        plan[1] = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        plan[2] = '{TARGET_DELAY_RST, UPDATE_PERIOD_RST, ALPHA_GAIN_RST, BETA_GAIN_RST,
                    PROB_CEILING_RST, BURST_ALLOWANCE_RST};
        plan[3] = random_settings();
        plan[4] = random_settings();
        plan[5] = random_settings();
        plan[5].prob_ceiling = 16'hFFFF;
        plan[6] = plan[5];
        plan[6].prob_ceiling = 16'd64;
        plan[7] = random_settings();
        plan[7].update_period = 16'd1;
        plan[8] = random_settings();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            load_settings(plan[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(random_item());
            drain();
        end

        // Let any stray result surface before the verdict
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("[pie_drop_controller] OK");
        else
            $display("[pie_drop_controller] ERROR");
        $finish;
    end

endmodule
